[hdl/uer_pkg.sv]
// Package for the ultrasonic echo ranger core.
// Holds register indexes, reset values, pulse lengths and state encodings.
// No dependencies.
`default_nettype none

package uer_pkg;

   localparam int unsigned TIMEOUT_W   = 16;
   localparam int unsigned DIVISOR_W   = 8;
   localparam int unsigned DIST_W      = 15;
   localparam int unsigned PULSE_W     = 4;
   localparam int unsigned CSR_ADDR_W  = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned REQ_DATA_W  = 8;
   localparam int unsigned RSP_DATA_W  = 24;
   localparam int unsigned DIV_STEPS   = 16;
   localparam int unsigned DIV_CNT_W   = 4;

   localparam logic [CSR_ADDR_W-1:0] CSR_ECHO_TIMEOUT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DIVISOR      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD    = 2'd2;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd30000;
   localparam logic [DIVISOR_W-1:0] DIVISOR_RESET   = 8'd58;
   localparam logic [DIST_W-1:0]    THRESHOLD_RESET = 15'd40;

   localparam logic [PULSE_W-1:0] TRIG_LOW_TICKS  = 4'd2;
   localparam logic [PULSE_W-1:0] TRIG_HIGH_TICKS = 4'd10;

   localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX = 16'hFFFF;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_TRIG_LOW  = 5'b00010,
      PH_TRIG_HIGH = 5'b00100,
      PH_WAIT_RISE = 5'b01000,
      PH_MEASURE   = 5'b10000
   } phase_type;

   typedef enum logic [2:0] {
      SQ_IDLE = 3'b001,
      SQ_DIV  = 3'b010,
      SQ_FIN  = 3'b100
   } seq_type;

endpackage

`default_nettype wire

[hdl/ultrasonic_echo_ranger_core.sv]
// Ultrasonic echo ranger core: trigger pulse, echo timing and distance calc.
// One shared restoring divider step serves the duration / divisor division.
// Depends on uer_pkg.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | req_tdata: start_req, echo
//  rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: trigger, busy_res, done_res,
//          |     |                        |            distance, closed
//  csr     | in  | csr_we                 | csr_addr, csr_wdata
//
// A tick that ends no measurement is answered on accept; its result is registered.
// A tick that ends a measurement passes through accept, 16 divider steps
// (one quotient bit each), then the final halving and threshold compare.
// req_tready is high only with the sequencer idle and the output free or draining.
// Synchronous active-high reset; no clearing pass.
`default_nettype none

module ultrasonic_echo_ranger_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [uer_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] start_req, [1] echo
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [uer_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [0] trigger, [1] busy_res,
                                                         // [2] done_res, [17:3] distance,
                                                         // [18] closed
   input  wire                              csr_we,
   input  wire  [uer_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire  [uer_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [uer_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [uer_pkg::DIVISOR_W-1:0] divisor_ff;
   logic [uer_pkg::DIST_W-1:0]    threshold_ff;

   uer_pkg::phase_type            phase_ff, phase_in;
   logic [uer_pkg::PULSE_W-1:0]   pulse_ff, pulse_in;
   logic [uer_pkg::TIMEOUT_W-1:0] elapsed_ff, elapsed_in;
   logic [uer_pkg::DIST_W-1:0]    dist_ff, dist_in;
   logic                          closed_ff, closed_in;

   uer_pkg::seq_type              seq_ff, seq_in;
   logic [uer_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [uer_pkg::DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [uer_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [uer_pkg::TIMEOUT_W-1:0] quo_ff, quo_in;

   logic                          out_valid_ff, out_valid_in;
   logic [uer_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic                          accept;
   logic                          start_req;
   logic                          echo;
   logic                          trig;
   logic                          fin;
   logic [uer_pkg::TIMEOUT_W-1:0] duration;
   logic [uer_pkg::PULSE_W-1:0]   pulse_inc;
   logic [uer_pkg::TIMEOUT_W-1:0] elapsed_sat;
   logic [uer_pkg::DIVISOR_W:0]   div_shift;
   logic                          div_ge;
   logic [uer_pkg::DIVISOR_W:0]   div_diff;
   logic [uer_pkg::DIST_W-1:0]    dist_new;

   assign start_req   = req_tdata[0];
   assign echo        = req_tdata[1];
   assign req_tready  = (seq_ff == uer_pkg::SQ_IDLE) && (!out_valid_ff || rsp_tready);
   assign accept      = req_tvalid && req_tready;
   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = out_data_ff;

   assign pulse_inc   = pulse_ff + 4'd1;
   assign elapsed_sat = (elapsed_ff == uer_pkg::ELAPSED_MAX) ? uer_pkg::ELAPSED_MAX
                                                             : elapsed_ff + 16'd1;

   // tick update
   always_comb begin
      phase_in = phase_ff;
      pulse_in = pulse_ff;
      elapsed_in = elapsed_ff;
      trig = 1'b0;
      fin = 1'b0;
      duration = '0;
      unique case (phase_ff)
         uer_pkg::PH_TRIG_LOW: begin
            pulse_in = pulse_inc;
            if (pulse_inc >= uer_pkg::TRIG_LOW_TICKS) begin
               phase_in = uer_pkg::PH_TRIG_HIGH;
               pulse_in = '0;
            end
         end
         uer_pkg::PH_TRIG_HIGH: begin
            trig = 1'b1;
            pulse_in = pulse_inc;
            if (pulse_inc >= uer_pkg::TRIG_HIGH_TICKS) begin
               phase_in = uer_pkg::PH_WAIT_RISE;
               pulse_in = '0;
               elapsed_in = '0;
            end
         end
         uer_pkg::PH_WAIT_RISE: begin
            if (echo) begin
               phase_in = uer_pkg::PH_MEASURE;
               elapsed_in = 16'd1;
               if (timeout_ff == '0) begin
                  fin = 1'b1;
                  duration = 16'd1;
               end
            end else begin
               elapsed_in = elapsed_sat;
               fin = elapsed_sat > timeout_ff;
            end
         end
         uer_pkg::PH_MEASURE: begin
            if (echo) begin
               elapsed_in = elapsed_sat;
               if (elapsed_sat > timeout_ff || elapsed_sat == uer_pkg::ELAPSED_MAX) begin
                  fin = 1'b1;
                  duration = elapsed_sat;
               end
            end else begin
               fin = 1'b1;
               duration = elapsed_ff;
            end
         end
         default: begin
            phase_in = uer_pkg::PH_IDLE;
            if (start_req) begin
               phase_in = uer_pkg::PH_TRIG_LOW;
               pulse_in = 4'd1;
               elapsed_in = '0;
            end
         end
      endcase
      if (fin) begin
         phase_in = uer_pkg::PH_IDLE;
         pulse_in = '0;
         elapsed_in = '0;
      end
   end

   // one restoring divide step
   assign div_shift = {rem_ff, quo_ff[uer_pkg::TIMEOUT_W-1]};
   assign div_ge    = div_shift >= {1'b0, dvs_ff};
   assign div_diff  = div_shift - {1'b0, dvs_ff};
   assign dist_new  = quo_ff[uer_pkg::TIMEOUT_W-1:1];

   always_comb begin
      seq_in = seq_ff;
      cnt_in = cnt_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dist_in = dist_ff;
      closed_in = closed_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      unique case (seq_ff)
         uer_pkg::SQ_IDLE: begin
            if (accept) begin
               if (fin) begin
                  seq_in = uer_pkg::SQ_DIV;
                  cnt_in = '0;
                  dvs_in = (divisor_ff == '0) ? 8'd1 : divisor_ff;
                  rem_in = '0;
                  quo_in = duration;
               end else begin
                  out_valid_in = 1'b1;
                  out_data_in = {5'd0, closed_ff, dist_ff, 1'b0,
                                 phase_in != uer_pkg::PH_IDLE, trig};
               end
            end
         end
         uer_pkg::SQ_DIV: begin
            rem_in = div_ge ? div_diff[uer_pkg::DIVISOR_W-1:0]
                            : div_shift[uer_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[uer_pkg::TIMEOUT_W-2:0], div_ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(uer_pkg::DIV_STEPS - 1)) begin
               seq_in = uer_pkg::SQ_FIN;
            end
         end
         uer_pkg::SQ_FIN: begin
            seq_in = uer_pkg::SQ_IDLE;
            dist_in = dist_new;
            closed_in = dist_new > threshold_ff;
            out_valid_in = 1'b1;
            out_data_in = {5'd0, dist_new > threshold_ff, dist_new, 1'b1, 1'b0, 1'b0};
         end
         default: begin
            seq_in = uer_pkg::SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= uer_pkg::TIMEOUT_RESET;
         divisor_ff <= uer_pkg::DIVISOR_RESET;
         threshold_ff <= uer_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            uer_pkg::CSR_ECHO_TIMEOUT: timeout_ff <= csr_wdata;
            uer_pkg::CSR_DIVISOR: divisor_ff <= csr_wdata[uer_pkg::DIVISOR_W-1:0];
            uer_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata[uer_pkg::DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uer_pkg::PH_IDLE;
         pulse_ff <= '0;
         elapsed_ff <= '0;
         dist_ff <= '0;
         closed_ff <= 1'b0;
         seq_ff <= uer_pkg::SQ_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            pulse_ff <= pulse_in;
            elapsed_ff <= elapsed_in;
         end
         dist_ff <= dist_in;
         closed_ff <= closed_in;
         seq_ff <= seq_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      out_data_ff <= out_data_in;
   end

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff[2]) |-> !out_data_ff[1])
      else $error("done beat reports busy");

   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff[0]) |-> out_data_ff[1])
      else $error("trigger high outside a measurement");

   a_div_no_out: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == uer_pkg::SQ_DIV) |-> !out_valid_ff)
      else $error("output pending while dividing");

   a_div_next: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == uer_pkg::SQ_DIV) |=> (seq_ff == uer_pkg::SQ_DIV || seq_ff == uer_pkg::SQ_FIN))
      else $error("divider left early");

   a_fin_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(seq_ff == uer_pkg::SQ_FIN) |-> $past(cnt_ff) == 4'(uer_pkg::DIV_STEPS - 1))
      else $error("divide step count wrong");

endmodule

`default_nettype wire
